/* rtl/core/cbgi_pkg.sv */
// Package: shared constants and types for the bilinear grid interpolator.
package cbgi_pkg;

    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 256;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int IDX_W    = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int CNT_W    = IDX_W + 1;
    localparam int BANK_D   = (MAX_ROWS / 2) * (MAX_COLS / 2);
    localparam int BANK_AW  = $clog2(BANK_D);
    localparam int DIV_Q    = IDX_W + 16;  // quotient bits: cell index and 16 fraction bits

    localparam logic [3:0] REG_ORIGIN_X1  = 4'd0;
    localparam logic [3:0] REG_ORIGIN_X2  = 4'd1;
    localparam logic [3:0] REG_SPACING_X1 = 4'd2;
    localparam logic [3:0] REG_SPACING_X2 = 4'd3;
    localparam logic [3:0] REG_ROWS_USED  = 4'd4;
    localparam logic [3:0] REG_COLS_USED  = 4'd5;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Per-axis location result
    typedef struct packed {
        logic        outside;
        logic [11:0] idx;
        logic [16:0] frac;   // Q0.16, 65536 means one
    } axis_loc_t;

endpackage

/* rtl/core/cbgi_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module cbgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/cbgi_axis.sv */
// Axis locator: extent test, pipelined restoring divide, clamping.
module cbgi_axis (
    input  logic                       clk,
    input  logic signed [31:0]         coord,
    input  logic signed [31:0]         origin,
    input  logic [30:0]                spacing,
    input  logic [cbgi_pkg::CNT_W-1:0] count,
    output cbgi_pkg::axis_loc_t        loc
);
    localparam int NQ = cbgi_pkg::DIV_Q;

    // stage 0: offset, extent, u and divisor
    logic [49:0]           rem_reg [NQ+1];   // running remainder, u scaled by 2^16
    logic [32:0]           dv_reg [NQ+1];    // 2*spacing
    logic [NQ-1:0]         q_reg [NQ+1];
    logic                  neg_reg [NQ+1];
    logic                  out_reg [NQ+1];
    logic [cbgi_pkg::CNT_W-1:0] cnt_reg [NQ+1];

    logic signed [33:0] d;
    logic [30:0]        s;
    logic [42:0]        ext;
    logic signed [34:0] u;

    always_comb
    begin
        s   = (spacing == 31'd0) ? 31'd1 : spacing;
        d   = 34'(coord) - 34'(origin);
        ext = 43'(count) * 43'(s);
        u   = 35'(d) * 35'sd2 - 35'($signed({1'b0, s}));
    end

    always_ff @(posedge clk)
    begin
        out_reg[0] <= d[33] || (43'(d) > ext);
        neg_reg[0] <= u[34];
        rem_reg[0] <= {u[33:0], 16'd0};
        dv_reg[0]  <= {s, 1'b0};
        q_reg[0]   <= '0;
        cnt_reg[0] <= count;
    end

    // One quotient bit per stage: u*2^16 / (2s), index in the top bits, fraction below.
    for (genvar k = 0; k < NQ; k++)
    begin : g_div
        localparam int SH = NQ - 1 - k;
        logic [56:0] num;
        logic [56:0] den;
        always_comb
        begin
            num = 57'(rem_reg[k]);
            den = 57'(dv_reg[k]) << SH;
        end
        always_ff @(posedge clk)
        begin
            if (num >= den)
            begin
                rem_reg[k+1] <= 50'(num - den);
                q_reg[k+1]   <= q_reg[k] | (NQ'(1) << SH);
            end
            else
            begin
                rem_reg[k+1] <= rem_reg[k];
                q_reg[k+1]   <= q_reg[k];
            end
            dv_reg[k+1]  <= dv_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            out_reg[k+1] <= out_reg[k];
            cnt_reg[k+1] <= cnt_reg[k];
        end
    end

    logic [11:0] qi;
    logic [11:0] lim;
    always_comb
    begin
        qi  = 12'(q_reg[NQ] >> 16);
        lim = 12'(cnt_reg[NQ] - cbgi_pkg::CNT_W'(2));
        loc.outside = out_reg[NQ];
        if (neg_reg[NQ])
        begin
            loc.idx  = '0;
            loc.frac = '0;
        end
        else if (qi > lim)
        begin
            loc.idx  = lim;
            loc.frac = 17'h10000;
        end
        else
        begin
            loc.idx  = qi;
            loc.frac = {1'b0, q_reg[NQ][15:0]};
        end
    end
endmodule

/* rtl/core/clamped_bilinear_grid_interp_unit.sv */
// Top level: grid store in four banks, two axis locators, blend and saturate.
// result_valid rises once an accepted query beat has passed the offset stage,
//   24 divider stages, bank read, two multiply stages, sum and saturate.
// Throughput: one beat per cycle; busy is held low, the divider is fully pipelined.
// Reset: rst_n returns the settings to their defaults and clears the valid chains; the grid store is not cleared.
// The receiver cannot stall; a result is shown for one cycle only.
module clamped_bilinear_grid_interp_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic [7:0]         load_row,
    input  logic [7:0]         load_col,
    input  logic signed [31:0] load_value,
    input  logic signed [31:0] coord_x1,
    input  logic signed [31:0] coord_x2,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               result_valid,
    output logic signed [31:0] value,
    output logic               outside
);
    localparam int NQ = cbgi_pkg::DIV_Q;
    localparam int DL = NQ + 1;

    logic signed [31:0] origin_x1_reg, origin_x2_reg;
    logic [30:0]        spacing_x1_reg, spacing_x2_reg;
    logic [8:0]         rows_used_reg, cols_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x1_reg  <= '0;
            origin_x2_reg  <= '0;
            spacing_x1_reg <= 31'd16777216;
            spacing_x2_reg <= 31'd16777216;
            rows_used_reg  <= 9'd256;
            cols_used_reg  <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cbgi_pkg::REG_ORIGIN_X1:  origin_x1_reg  <= cfg_data;
                cbgi_pkg::REG_ORIGIN_X2:  origin_x2_reg  <= cfg_data;
                cbgi_pkg::REG_SPACING_X1: spacing_x1_reg <= cfg_data[30:0];
                cbgi_pkg::REG_SPACING_X2: spacing_x2_reg <= cfg_data[30:0];
                cbgi_pkg::REG_ROWS_USED:  rows_used_reg  <= cfg_data[8:0];
                cbgi_pkg::REG_COLS_USED:  cols_used_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // saturated counts
    logic [cbgi_pkg::CNT_W-1:0] n1, n2;
    always_comb
    begin
        n1 = (rows_used_reg < 9'd2) ? cbgi_pkg::CNT_W'(2) :
             (rows_used_reg > 9'(cbgi_pkg::MAX_ROWS)) ? cbgi_pkg::CNT_W'(cbgi_pkg::MAX_ROWS)
             : cbgi_pkg::CNT_W'(rows_used_reg);
        n2 = (cols_used_reg < 9'd2) ? cbgi_pkg::CNT_W'(2) :
             (cols_used_reg > 9'(cbgi_pkg::MAX_COLS)) ? cbgi_pkg::CNT_W'(cbgi_pkg::MAX_COLS)
             : cbgi_pkg::CNT_W'(cols_used_reg);
    end

    logic q_in, ld_in;
    assign q_in  = start && !busy && (cmd == cbgi_pkg::CMD_QUERY);
    assign ld_in = start && !busy && (cmd == cbgi_pkg::CMD_LOAD);

    cbgi_pkg::axis_loc_t loc1, loc2;
    cbgi_axis u_ax1 (.clk, .coord(coord_x1), .origin(origin_x1_reg),
                     .spacing(spacing_x1_reg), .count(n1), .loc(loc1));
    cbgi_axis u_ax2 (.clk, .coord(coord_x2), .origin(origin_x2_reg),
                     .spacing(spacing_x2_reg), .count(n2), .loc(loc2));

    // query valid chain alongside the divider; load beats trail by the same depth
    // so a read sees exactly the loads accepted before its query
    logic [DL-1:0] qv_reg;
    logic [DL-1:0] ldv_reg;
    logic [4:0]    pv_reg;   // read, mult1, mult2, sum, out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg  <= '0;
            ldv_reg <= '0;
            pv_reg  <= '0;
        end
        else
        begin
            qv_reg  <= {qv_reg[DL-2:0], q_in};
            ldv_reg <= {ldv_reg[DL-2:0], ld_in};
            pv_reg  <= {pv_reg[3:0], qv_reg[DL-1]};
        end
    end

    logic [7:0]  ldr_reg [DL];
    logic [7:0]  ldc_reg [DL];
    logic [31:0] ldd_reg [DL];
    always_ff @(posedge clk)
    begin
        ldr_reg[0] <= load_row;
        ldc_reg[0] <= load_col;
        ldd_reg[0] <= load_value;
        for (int k = 1; k < DL; k++)
        begin
            ldr_reg[k] <= ldr_reg[k-1];
            ldc_reg[k] <= ldc_reg[k-1];
            ldd_reg[k] <= ldd_reg[k-1];
        end
    end

    // Banks by row and column parity so the four neighbours sit in distinct banks.
    logic [11:0] i, j, i1, j1;
    assign i  = loc1.idx;
    assign j  = loc2.idx;
    assign i1 = i + 12'd1;
    assign j1 = j + 12'd1;

    logic [31:0] bank_q [4];
    logic [1:0]  bsel_reg;
    logic [16:0] f1_reg, f2_reg;
    logic        out_p_reg;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic RP = 1'(b >> 1);
        localparam logic CP = 1'(b);
        logic [11:0] rr, cc;
        logic [7:0]  wr, wc;
        logic [cbgi_pkg::BANK_AW-1:0] ra, wa;
        logic we;
        always_comb
        begin
            rr = (i[0] == RP) ? i : i1;
            cc = (j[0] == CP) ? j : j1;
            wr = ldr_reg[DL-1];
            wc = ldc_reg[DL-1];
            ra = {rr[cbgi_pkg::ROW_W-1:1], cc[cbgi_pkg::COL_W-1:1]};
            wa = {wr[cbgi_pkg::ROW_W-1:1], wc[cbgi_pkg::COL_W-1:1]};
            we = ldv_reg[DL-1] && (wr[0] == RP) && (wc[0] == CP);
        end
        cbgi_ram #(.WIDTH(32), .DEPTH(cbgi_pkg::BANK_D)) u_ram (
            .clk, .we, .waddr(wa), .wdata(ldd_reg[DL-1]), .raddr(ra), .rdata(bank_q[b]));
    end

    always_ff @(posedge clk)
    begin
        bsel_reg  <= {i[0], j[0]};
        f1_reg    <= loc1.frac;
        f2_reg    <= loc2.frac;
        out_p_reg <= loc1.outside || loc2.outside;
    end

    // s00 at (i,j): bank {i0,j0}
    logic signed [31:0] s00, s01, s10, s11;
    always_comb
    begin
        s00 = bank_q[{bsel_reg[1],  bsel_reg[0]}];
        s01 = bank_q[{bsel_reg[1], ~bsel_reg[0]}];
        s10 = bank_q[{~bsel_reg[1],  bsel_reg[0]}];
        s11 = bank_q[{~bsel_reg[1], ~bsel_reg[0]}];
    end

    // weights, Q0.16 (17 bits to hold one)
    logic [16:0] g1, g2;
    assign g1 = 17'h10000 - f1_reg;
    assign g2 = 17'h10000 - f2_reg;

    logic signed [49:0] a_reg [4];   // sample * first-axis weight
    logic [16:0]        w2_reg [4];
    logic               out_m_reg;
    always_ff @(posedge clk)
    begin
        a_reg[0]  <= 50'(s00) * $signed({1'b0, g1});
        a_reg[1]  <= 50'(s01) * $signed({1'b0, g1});
        a_reg[2]  <= 50'(s10) * $signed({1'b0, f1_reg});
        a_reg[3]  <= 50'(s11) * $signed({1'b0, f1_reg});
        w2_reg[0] <= g2;
        w2_reg[1] <= f2_reg;
        w2_reg[2] <= g2;
        w2_reg[3] <= f2_reg;
        out_m_reg <= out_p_reg;
    end

    logic signed [67:0] p_reg [4];
    logic               out_s_reg;
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            p_reg[k] <= 68'(a_reg[k]) * $signed({1'b0, w2_reg[k]});
        end
        out_s_reg <= out_m_reg;
    end

    logic signed [67:0] acc_reg;
    logic               out_a_reg;
    always_ff @(posedge clk)
    begin
        acc_reg   <= p_reg[0] + p_reg[1] + p_reg[2] + p_reg[3] + 68'sh8000_0000;
        out_a_reg <= out_s_reg;
    end

    logic signed [35:0] v;
    assign v = 36'(acc_reg >>> 32);

    logic signed [31:0] value_reg;
    logic               outside_reg;
    always_ff @(posedge clk)
    begin
        outside_reg <= out_a_reg;
        if (out_a_reg)
        begin
            value_reg <= '0;
        end
        else if (v > 36'sh0_7FFF_FFFF)
        begin
            value_reg <= 32'h7FFF_FFFF;
        end
        else if (v < -36'sh0_8000_0000)
        begin
            value_reg <= 32'h8000_0000;
        end
        else
        begin
            value_reg <= v[31:0];
        end
    end

    assign result_valid = pv_reg[4];
    assign value        = value_reg;
    assign outside      = outside_reg;
endmodule

/* rtl/core/cbgi_checker.sv */
// Port-level checker for the interpolator, bound to the top level.
module cbgi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               cmd,
    input logic               result_valid,
    input logic signed [31:0] value,
    input logic               outside
);
    // sampled at the edge that follows the rise of result_valid
    localparam int LAT = cbgi_pkg::DIV_Q + 6;

    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && outside |-> value == 32'sd0) else $error("outside not zero");
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy) else $error("busy raised");
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy && cmd) |-> ##LAT !result_valid) else $error("result without query");
    a_query_res: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd |-> ##LAT result_valid) else $error("query result lost");
endmodule

bind clamped_bilinear_grid_interp_unit cbgi_checker u_chk (.clk, .rst_n, .start, .busy,
    .cmd, .result_valid, .value, .outside);

/* verif/clamped_bilinear_grid_interp_unit_test.sv */
// Self-checking testbench for the clamped bilinear grid interpolator: loads, queries, settings.
module clamped_bilinear_grid_interp_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cbgi_pkg::*;

    // Not a register of the block: writes here must be ignored
    localparam logic [3:0] REG_SPARE = 4'd9;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic               op;
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [31:0] sample;
        logic signed [31:0] x1;
        logic signed [31:0] x2;
    } grid_beat_t;

    typedef struct {
        logic signed [31:0] blend;
        logic               off_grid;
    } blend_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               cmd = CMD_LOAD;
    logic [7:0]         load_row = '0;
    logic [7:0]         load_col = '0;
    logic signed [31:0] load_value = '0;
    logic signed [31:0] coord_x1 = '0;
    logic signed [31:0] coord_x2 = '0;
    logic               cfg_we = 1'b0;
    logic [3:0]         cfg_index = REG_ORIGIN_X1;
    logic [31:0]        cfg_data = '0;
    logic               result_valid;
    logic signed [31:0] value;
    logic               outside;

    clamped_bilinear_grid_interp_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .load_row(load_row), .load_col(load_col), .load_value(load_value),
        .coord_x1(coord_x1), .coord_x2(coord_x2), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .result_valid(result_valid),
        .value(value), .outside(outside)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow of the block's settings and grid, owned by the predictor
    logic signed [31:0] org1 = 0, org2 = 0;
    logic [30:0]        pitch1 = 31'd16777216, pitch2 = 31'd16777216;
    logic [8:0]         nrows = 9'd256, ncols = 9'd256;
    logic [31:0]        grid_mem [MAX_ROWS*MAX_COLS];
    // Which entries the stimulus has loaded so far (generation side)
    bit                 loaded [MAX_ROWS*MAX_COLS];

    grid_beat_t    beat_q [$];
    blend_result_t blend_q [$];
    grid_beat_t    cur_beat;
    int            idle_left = 0;
    bit            calm = 0;
    int            idle_cycles = 0;
    int            errors = 0;
    int            n_built = 0;
    int            n_loads = 0, n_queries = 0, n_off = 0, n_phases = 0;

    function automatic longint clamp_count(input logic [8:0] n, input int maxn);
        longint c;
        c = n;
        if (c < 2) c = 2;
        if (c > maxn) c = maxn;
        return c;
    endfunction

    // Lower cell index and Q0.16 fraction on one axis; returns 1 when off the grid
    function automatic bit locate_cell(input longint coord, input longint origin,
                                       input logic [30:0] pitch, input longint cnt,
                                       output longint idx, output longint frac);
        longint s, d, u, q, r;
        s = (pitch == 0) ? 1 : pitch;
        d = coord - origin;
        idx = 0;
        frac = 0;
        if (d < 0 || d > cnt * s) return 1;
        u = 2 * d - s;
        if (u < 0) return 0;       // below the first cell centre
        q = u / (2 * s);
        r = u % (2 * s);
        if (q > cnt - 2)
        begin
            idx = cnt - 2;         // above the last centre: full weight on the upper cell
            frac = 65536;
        end
        else
        begin
            idx = q;
            frac = (r << 16) / (2 * s);
        end
        return 0;
    endfunction

    task automatic predict_beat(input grid_beat_t b);
        longint i, j, f1, f2, g1, g2, acc, v;
        int base;
        blend_result_t res;
        if (b.op == CMD_LOAD)
        begin
            grid_mem[{b.row, b.col}] = b.sample;
            n_loads++;
            return;
        end
        n_queries++;
        if (locate_cell(b.x1, org1, pitch1, clamp_count(nrows, MAX_ROWS), i, f1) ||
            locate_cell(b.x2, org2, pitch2, clamp_count(ncols, MAX_COLS), j, f2))
        begin
            res.blend = 0;
            res.off_grid = 1'b1;
            n_off++;
        end
        else
        begin
            g1 = 65536 - f1;
            g2 = 65536 - f2;
            base = int'(i * MAX_COLS + j);
            acc = longint'($signed(grid_mem[base])) * (g1 * g2);
            acc += longint'($signed(grid_mem[base + 1])) * (g1 * f2);
            acc += longint'($signed(grid_mem[base + MAX_COLS])) * (f1 * g2);
            acc += longint'($signed(grid_mem[base + MAX_COLS + 1])) * (f1 * f2);
            v = (acc + 64'sh8000_0000) >>> 32;   // round half up
            if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
            if (v < -64'sh8000_0000) v = -64'sh8000_0000;
            res.blend = v[31:0];
            res.off_grid = 1'b0;
        end
        blend_q.push_back(res);
    endtask

    // Driver: one beat per handshake, random bursts of idling from the sender
    always @(posedge clk)
    begin
        logic nxt_start;
        grid_beat_t b;
        if (rst_n)
        begin
            if (start && !busy)
                predict_beat(cur_beat);
            nxt_start = 1'b0;
            if (start && busy)
                nxt_start = 1'b1;          // hold the beat until taken
            else if (idle_left > 0)
                idle_left--;
            else if (beat_q.size() > 0)
            begin
                if (!calm && $urandom_range(0, 7) == 0)
                    idle_left = $urandom_range(1, 6);
                else
                begin
                    b = beat_q.pop_front();
                    cur_beat = b;
                    cmd <= b.op;
                    load_row <= b.row;
                    load_col <= b.col;
                    load_value <= b.sample;
                    coord_x1 <= b.x1;
                    coord_x2 <= b.x2;
                    nxt_start = 1'b1;
                end
            end
            start <= nxt_start;
        end
    end

    // Monitor: a result strobe must meet the oldest expected blend
    always @(posedge clk)
    begin
        blend_result_t e;
        if (rst_n && result_valid)
        begin
            if (blend_q.size() == 0)
            begin
                $error("result with nothing expected: value %0d outside %0b", value, outside);
                errors++;
            end
            else
            begin
                e = blend_q.pop_front();
                if (value !== e.blend)
                begin
                    $error("value: expected %0d, got %0d", e.blend, value);
                    errors++;
                end
                if (outside !== e.off_grid)
                begin
                    $error("outside: expected %0b, got %0b", e.off_grid, outside);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("clamped_bilinear_grid_interp_unit: mismatch");
            $finish;
        end
    end

    function automatic longint rand_upto(input longint n);
        longint r;
        r = {$urandom, $urandom};
        r = r & 64'h7FFF_FFFF_FFFF_FFFF;
        return r % (n + 1);
    endfunction

    task automatic add_load(input int r, input int c, input logic [31:0] v);
        grid_beat_t b;
        b.op = CMD_LOAD;
        b.row = 8'(r);
        b.col = 8'(c);
        b.sample = v;
        b.x1 = $urandom;
        b.x2 = $urandom;
        loaded[r * MAX_COLS + c] = 1;
        beat_q.push_back(b);
        n_built++;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Queue a query; loads any of its four neighbours not yet written first
    task automatic add_query(input logic [31:0] x1, input logic [31:0] x2);
        grid_beat_t b;
        longint i, j, f1, f2;
        if (!(locate_cell($signed(x1), org1, pitch1, clamp_count(nrows, MAX_ROWS), i, f1) ||
              locate_cell($signed(x2), org2, pitch2, clamp_count(ncols, MAX_COLS), j, f2)))
        begin
            for (int a = 0; a < 2; a++)
                for (int c = 0; c < 2; c++)
                    if (!loaded[(i + a) * MAX_COLS + j + c])
                        add_load(int'(i + a), int'(j + c), rand_sample());
        end
        b.op = CMD_QUERY;
        b.row = $urandom;
        b.col = $urandom;
        b.sample = $urandom;
        b.x1 = x1;
        b.x2 = x2;
        beat_q.push_back(b);
        n_built++;
    endtask

    // Coordinate on one axis: mostly on the grid, some at the ends, some off it
    function automatic logic [31:0] pick_coord(input logic signed [31:0] origin,
                                               input logic [30:0] pitch, input logic [8:0] n,
                                               input int maxn);
        longint s, span, d, c;
        s = (pitch == 0) ? 1 : pitch;
        span = clamp_count(n, maxn) * s;
        case ($urandom_range(0, 9))
            0: d = 0;
            1: d = span;
            2: d = $urandom_range(0, 1) ? -rand_upto(s) - 1 : span + 1 + rand_upto(s);
            3: return $urandom;
            default: d = rand_upto(span);
        endcase
        c = origin + d;
        if (c > 64'sh7FFF_FFFF || c < -64'sh8000_0000)
            return $urandom;
        return c[31:0];
    endfunction

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_ORIGIN_X1:  org1 = data;
            REG_ORIGIN_X2:  org2 = data;
            REG_SPACING_X1: pitch1 = data[30:0];
            REG_SPACING_X2: pitch2 = data[30:0];
            REG_ROWS_USED:  nrows = data[8:0];
            REG_COLS_USED:  ncols = data[8:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [31:0] o1, input logic [31:0] o2,
                            input logic [31:0] s1, input logic [31:0] s2,
                            input logic [31:0] nr, input logic [31:0] nc);
        write_reg(REG_ORIGIN_X1, o1);
        write_reg(REG_ORIGIN_X2, o2);
        write_reg(REG_SPACING_X1, s1);
        write_reg(REG_SPACING_X2, s2);
        write_reg(REG_ROWS_USED, nr);
        write_reg(REG_COLS_USED, nc);
        write_reg(REG_SPARE, $urandom);   // must leave every setting alone
        @(posedge clk);
        cfg_we <= 1'b0;
        n_phases++;
    endtask

    // Block is idle once the sender is empty and every blend has come back
    task automatic wait_drained();
        while (beat_q.size() != 0 || start || idle_left != 0 || blend_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Queues about count beats, neighbour loads included
    task automatic random_phase(input int count);
        int stop_at;
        stop_at = n_built + count;
        while (n_built < stop_at)
        begin
            if ($urandom_range(0, 3) == 0)
                add_load($urandom_range(0, 255), $urandom_range(0, 255), rand_sample());
            else
                add_query(pick_coord(org1, pitch1, nrows, MAX_ROWS),
                          pick_coord(org2, pitch2, ncols, MAX_COLS));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 3x3 grid of unit cells starting at -1.0
        set_grid(32'hFF00_0000, 32'hFF00_0000, 32'h0100_0000, 32'h0100_0000, 3, 3);
        add_load(0, 0, 32'h7FFF_FFFF);
        add_load(0, 1, 32'h8000_0000);
        add_load(1, 0, 32'h7FFF_FFFF);
        add_load(1, 1, 32'h7FFF_FFFF);
        add_load(255, 255, 32'h0001_0000);
        add_query(32'hFF00_0000, 32'hFF00_0000);   // grid start, below first centre
        add_query(32'h0200_0000, 32'h0200_0000);   // far end, above last centre
        add_query(32'hFEFF_FFFF, 32'h0000_0000);   // just before the start
        add_query(32'h0000_0000, 32'h0200_0001);   // just past the end
        add_query(32'h8000_0000, 32'h7FFF_FFFF);   // coordinate extremes
        add_query(32'h7FFF_FFFF, 32'h0000_0000);
        add_query(32'hFF80_0000, 32'hFF80_0000);   // first centre exactly
        add_query(32'h0000_0000, 32'hFFC0_0000);   // between centres
        add_query(32'h0180_0000, 32'h0100_0000);   // last centre on first axis
        add_query(32'hFFFF_FFFF, 32'h0000_0001);
        wait_drained();

        // Extremes and random settings; counts and spacings out of range saturate
        set_grid(0, 0, 32'h0100_0000, 32'h0100_0000, 256, 256);
        random_phase(110);
        wait_drained();
        set_grid($urandom, $urandom, 1, 0, 0, 1);
        random_phase(100);
        wait_drained();
        set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0010_0000, 511, 300);
        random_phase(100);
        wait_drained();
        set_grid(32'hC000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2, 256);
        random_phase(100);
        wait_drained();
        for (int p = 0; p < 3; p++)
        begin
            set_grid($urandom, $urandom, $urandom_range(1, 32'h0400_0000),
                     $urandom_range(1, 32'h0400_0000), $urandom_range(2, 256),
                     $urandom_range(2, 256));
            random_phase(110);
            wait_drained();
        end
        // Closing stretch: sender runs flat out
        calm = 1;
        set_grid(32'hFE00_0000, 32'h0000_0000, 32'h0080_0000, 32'h0300_0000, 16, 7);
        random_phase(90);
        wait_drained();

        $display("covered %0d loads and %0d queries (%0d off the grid) over %0d settings",
                 n_loads, n_queries, n_off, n_phases);
        if (errors == 0)
            $display("clamped_bilinear_grid_interp_unit: match");
        else
            $display("clamped_bilinear_grid_interp_unit: mismatch");
        $finish;
    end
endmodule
